/* hw/rtl/vsaso_pkg.sv */
// Shared types and constants for the voice slot allocator.
`timescale 1ns / 1ps
package vsaso_pkg;

    localparam int VOICES_DEF = 32;
    localparam int FRAME_W    = 48;
    localparam int SLOT_W     = 5;
    localparam int LIVE_W     = 6;
    localparam int S_TDATA_W  = 96;
    localparam int M_TDATA_W  = 16;

    typedef enum logic {
        OP_ALLOC   = 1'b0,
        OP_ADVANCE = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic issue;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_last;
        logic out_free;
    } t_dp_sts;

endpackage

/* hw/rtl/vsaso_ctrl.sv */
// Sequencer for request intake, slot scan and result commit.
`timescale 1ns / 1ps
module vsaso_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  vsaso_pkg::t_dp_sts i_sts,
    output vsaso_pkg::t_dp_cmd o_cmd
);
    import vsaso_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (i_sts.scan_last) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                n_state = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (i_sts.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                o_cmd.load = i_s_tvalid;
            end
            ST_SCAN: begin
                o_cmd.issue = 1'b1;
            end
            ST_DRAIN: begin
            end
            ST_COMMIT: begin
                o_cmd.commit = i_sts.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

/* hw/rtl/vsaso_dp.sv */
// Slot table, scan evaluation and result register.
`timescale 1ns / 1ps
module vsaso_dp #(
    parameter int VOICES = vsaso_pkg::VOICES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  vsaso_pkg::t_dp_cmd               i_cmd,
    output vsaso_pkg::t_dp_sts               o_sts,
    input  logic                             i_op,
    input  logic [vsaso_pkg::FRAME_W-1:0]    i_end_frame,
    input  logic [vsaso_pkg::FRAME_W-1:0]    i_render_head,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [vsaso_pkg::M_TDATA_W-1:0]  o_m_tdata
);
    import vsaso_pkg::*;

    localparam int IDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int CNT_W = $clog2(VOICES + 1);

    logic [FRAME_W-1:0] mem [VOICES];

    logic [VOICES-1:0]  r_active;
    logic [CNT_W-1:0]   r_live;
    logic [IDX_W-1:0]   r_idx;
    logic               r_eval;
    logic [IDX_W-1:0]   r_eval_idx;
    logic [FRAME_W-1:0] r_rd_data;
    logic               r_op;
    logic [FRAME_W-1:0] r_endf;
    logic [FRAME_W-1:0] r_head;
    logic               r_free_found;
    logic [IDX_W-1:0]   r_free_idx;
    logic               r_min_vld;
    logic [FRAME_W-1:0] r_min;
    logic [IDX_W-1:0]   r_min_idx;
    logic               r_m_tvalid;
    logic [M_TDATA_W-1:0] r_m_tdata;

    logic               eval_act;
    logic               is_alloc;
    logic [IDX_W-1:0]   pick;
    logic [CNT_W-1:0]   live_next;
    logic [IDX_W+SLOT_W-1:0] slot_ext;
    logic [CNT_W+LIVE_W-1:0] live_ext;
    logic [SLOT_W-1:0]  slot_out;
    logic               stole_out;

    assign eval_act  = r_eval & r_active[r_eval_idx];
    assign is_alloc  = (r_op == OP_ALLOC);
    assign pick      = r_free_found ? r_free_idx : r_min_idx;
    assign live_next = (is_alloc && r_free_found) ? r_live + CNT_W'(1) : r_live;
    assign slot_ext  = {{SLOT_W{1'b0}}, pick};
    assign live_ext  = {{LIVE_W{1'b0}}, live_next};
    assign slot_out  = is_alloc ? slot_ext[SLOT_W-1:0] : '0;
    assign stole_out = is_alloc & ~r_free_found;

    assign o_sts.scan_last = (r_idx == IDX_W'(VOICES - 1));
    assign o_sts.out_free  = ~r_m_tvalid | i_m_tready;
    assign o_m_tvalid      = r_m_tvalid;
    assign o_m_tdata       = r_m_tdata;

    // end frame store, one read and one write port
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && is_alloc) begin
            mem[pick] <= r_endf;
        end
        if (i_cmd.issue) begin
            r_rd_data <= mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_op;
            r_endf <= i_end_frame;
            r_head <= i_render_head;
        end
        if (i_cmd.issue) begin
            r_eval_idx <= r_idx;
        end
        if (r_eval && is_alloc) begin
            if (!r_active[r_eval_idx] && !r_free_found) begin
                r_free_idx <= r_eval_idx;
            end
            if (eval_act && (!r_min_vld || r_rd_data < r_min)) begin
                r_min     <= r_rd_data;
                r_min_idx <= r_eval_idx;
            end
        end
        if (i_cmd.commit) begin
            r_m_tdata <= M_TDATA_W'({live_ext[LIVE_W-1:0], stole_out, slot_out});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active     <= '0;
            r_live       <= '0;
            r_idx        <= '0;
            r_eval       <= 1'b0;
            r_free_found <= 1'b0;
            r_min_vld    <= 1'b0;
            r_m_tvalid   <= 1'b0;
        end else begin
            r_eval <= i_cmd.issue;
            if (i_cmd.load) begin
                r_idx        <= '0;
                r_free_found <= 1'b0;
                r_min_vld    <= 1'b0;
            end else if (i_cmd.issue) begin
                r_idx <= r_idx + IDX_W'(1);
            end
            if (r_eval && is_alloc) begin
                if (!r_active[r_eval_idx]) begin
                    r_free_found <= 1'b1;
                end else if (!r_min_vld || r_rd_data < r_min) begin
                    r_min_vld <= 1'b1;
                end
            end
            // retire on advance, one slot per cycle
            if (eval_act && !is_alloc && r_rd_data <= r_head) begin
                r_active[r_eval_idx] <= 1'b0;
                r_live               <= r_live - CNT_W'(1);
            end
            if (i_cmd.commit) begin
                if (is_alloc) begin
                    r_active[pick] <= 1'b1;
                end
                r_live     <= live_next;
                r_m_tvalid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

endmodule

/* hw/rtl/voice_slot_allocator_steal_oldest_top.sv */
// Top level of the voice slot allocator with steal-oldest.
//
//  channel | dir | tdata (low bit up)                      | tuser
//  s       | in  | end_frame[47:0], render_head[95:48]     | opcode
//  m       | out | slot[4:0], stole[5], live_count[11:6]   | -
//
// Each request runs a scan that reads one end frame per cycle through the
// slot table's one read port.
// Synchronous active-low reset clears all active flags and the live count.
// A finished result waits in the output register; a new request is taken
// meanwhile, and its commit waits until the previous result is taken.
`timescale 1ns / 1ps
module voice_slot_allocator_steal_oldest_top #(
    parameter int VOICES = vsaso_pkg::VOICES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [vsaso_pkg::S_TDATA_W-1:0]  i_s_tdata,  // end_frame, render_head
    input  logic                             i_s_tuser,  // opcode
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [vsaso_pkg::M_TDATA_W-1:0]  o_m_tdata   // slot, stole, live_count
);
    import vsaso_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    vsaso_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    vsaso_dp #(
        .VOICES (VOICES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_op          (i_s_tuser),
        .i_end_frame   (i_s_tdata[FRAME_W-1:0]),
        .i_render_head (i_s_tdata[2*FRAME_W-1:FRAME_W]),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata)
    );

endmodule
